// ----- rtl/tbp_pkg.sv -----
// tbp_pkg: constants and types of the tournament branch predictor
// no dependencies; used by the channel interfaces, the table RAM user and the top level
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

	// table geometry
	localparam int PATTERN_INDEX_BITS  = 10;
	localparam int LOCAL_INDEX_BITS    = 7;
	localparam int GLOBAL_HISTORY_BITS = 10;

	// gshare drops the low pc index bits the global history cannot cover
	localparam int GSHARE_PC_SHIFT = (PATTERN_INDEX_BITS > GLOBAL_HISTORY_BITS) ?
		(PATTERN_INDEX_BITS - GLOBAL_HISTORY_BITS) : 0;

	// clearing pass walks the larger of the two indexed tables
	localparam int CLEAR_BITS = (PATTERN_INDEX_BITS > LOCAL_INDEX_BITS) ?
		PATTERN_INDEX_BITS : LOCAL_INDEX_BITS;

	// payload widths
	localparam int PC_BITS    = 64;
	localparam int COUNT_BITS = 32;
	localparam int CTR_BITS   = 2;

	// configuration port
	localparam int MODE_BITS      = 3;
	localparam int SHIFT_BITS     = 5;
	localparam int CFG_DATA_BITS  = 5;
	localparam int CFG_INDEX_BITS = 1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MODE     = 1'b0,
		CFG_PC_SHIFT = 1'b1
	} cfg_idx_t;

	// predictor modes; codes above tournament behave as tournament
	typedef enum logic [MODE_BITS-1:0] {
		MODE_ONE_LEVEL  = 3'd0,
		MODE_GLOBAL     = 3'd1,
		MODE_GSHARE     = 3'd2,
		MODE_LOCAL      = 3'd3,
		MODE_TOURNAMENT = 3'd4
	} mode_t;

	// reset values
	localparam logic [MODE_BITS-1:0]  MODE_RESET     = MODE_TOURNAMENT;
	localparam logic [SHIFT_BITS-1:0] PC_SHIFT_RESET = 5'd5;
	localparam logic [CTR_BITS-1:0]   PATTERN_RESET  = 2'b00;
	localparam logic [CTR_BITS-1:0]   CHOOSER_RESET  = 2'b01;
	localparam logic [CTR_BITS-1:0]   CTR_MAX        = 2'd3;

endpackage : tbp_pkg

`default_nettype wire

// ----- rtl/tbp_branch_if.sv -----
// tbp_branch_if: valid/ready channel carrying one resolved branch
// depends on tbp_pkg for the pc width
`timescale 1ns / 1ps
`default_nettype none

interface tbp_branch_if;
	import tbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [PC_BITS-1:0]  branch_pc;
	logic                taken;

	modport source (output valid, output branch_pc, output taken, input ready);
	modport sink   (input valid, input branch_pc, input taken, output ready);

endinterface : tbp_branch_if

`default_nettype wire

// ----- rtl/tbp_result_if.sv -----
// tbp_result_if: valid/ready channel carrying one prediction result with running counts
// depends on tbp_pkg for the count width
`timescale 1ns / 1ps
`default_nettype none

interface tbp_result_if;
	import tbp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   predicted_taken;
	logic                   correct;
	logic [COUNT_BITS-1:0]  hits_taken;
	logic [COUNT_BITS-1:0]  misses_taken;
	logic [COUNT_BITS-1:0]  hits_not_taken;
	logic [COUNT_BITS-1:0]  misses_not_taken;

	modport source (
		output valid, output predicted_taken, output correct,
		output hits_taken, output misses_taken, output hits_not_taken, output misses_not_taken,
		input ready
	);
	modport sink (
		input valid, input predicted_taken, input correct,
		input hits_taken, input misses_taken, input hits_not_taken, input misses_not_taken,
		output ready
	);

endinterface : tbp_result_if

`default_nettype wire

// ----- rtl/tournament_branch_predictor.sv -----
// tournament_branch_predictor: top level, pipeline, forwarding, history and outcome counters
// depends on tbp_pkg, tbp_branch_if, tbp_result_if and tbp_ram
`timescale 1ns / 1ps
`default_nettype none

// Accepts one resolved branch (pc, outcome) per clock unless the pipeline stalls, and
// returns one result per branch: the prediction made before training, whether it was
// right, and four saturating hit/miss counts. The rate is one branch per cycle while
// result.ready keeps the pipeline moving. A branch passes the local history read, the
// pattern and chooser read and training in that order, the two reads each set by a
// registered memory read port, with write-to-read forwarding so that consecutive
// branches see each other's updates. After reset the block runs a clearing pass over all
// 2**CLEAR_BITS addresses (1024 with the default tables) that sets the pattern, chooser
// and local history tables; branch.ready stays low meanwhile, while configuration writes
// are taken at any time. Configuration should only be written while no branch is in flight.
module tournament_branch_predictor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  tbp_pkg::cfg_idx_t                    cfg_index,
	input  logic [tbp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	tbp_branch_if.sink                           branch,
	tbp_result_if.source                         result
);
	import tbp_pkg::*;

	// 2-bit saturating counter step
	function automatic logic [CTR_BITS-1:0] ctr_step(input logic [CTR_BITS-1:0] ctr,
		input logic up);
		logic [CTR_BITS-1:0] nxt;
		nxt = ctr;
		if (up) begin
			if (ctr != CTR_MAX) nxt = ctr + CTR_BITS'(1);
		end else begin
			if (ctr != '0) nxt = ctr - CTR_BITS'(1);
		end
		return nxt;
	endfunction

	// configuration registers
	logic [MODE_BITS-1:0]  mode_q;
	logic [SHIFT_BITS-1:0] pc_shift_q;

	// clearing pass
	logic                  clr_q;
	logic [CLEAR_BITS-1:0] clr_cnt_q;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3;
	logic load_s1, load_s2, load_s3;
	logic accept, leave_s1, leave_s2;

	// stage 1 payload
	logic [PATTERN_INDEX_BITS-1:0] pcv_s1;
	logic [LOCAL_INDEX_BITS-1:0]   lix_s1;
	logic                          taken_s1;

	// stage 2 payload
	logic [PATTERN_INDEX_BITS-1:0] pcv_s2;
	logic [PATTERN_INDEX_BITS-1:0] aidx_s2;
	logic [PATTERN_INDEX_BITS-1:0] lidx_s2;
	logic                          taken_s2;

	// stage 3 payload
	logic pred_s3;
	logic correct_s3;

	// history and outcome state
	logic [GLOBAL_HISTORY_BITS-1:0] ghist_q;
	logic [COUNT_BITS-1:0] hits_taken_q, misses_taken_q, hits_not_taken_q, misses_not_taken_q;

	// forwarding registers: last write to each table
	logic                          lbyp_v_q;
	logic [LOCAL_INDEX_BITS-1:0]   lbyp_addr_q;
	logic [PATTERN_INDEX_BITS-1:0] lbyp_data_q;
	logic                          pbyp_v_q;
	logic [PATTERN_INDEX_BITS-1:0] pbyp_addr_q;
	logic [CTR_BITS-1:0]           pbyp_data_q;
	logic                          cbyp_v_q;
	logic [PATTERN_INDEX_BITS-1:0] cbyp_addr_q;
	logic [CTR_BITS-1:0]           cbyp_data_q;

	// mode decode
	logic mode_tourn, upd_global, upd_local;

	// stage 0 combinational
	logic [PC_BITS-1:0]            pc_shifted;
	logic [PATTERN_INDEX_BITS-1:0] pcv_in;
	logic [LOCAL_INDEX_BITS-1:0]   lix_in;

	// stage 1 combinational
	logic [PATTERN_INDEX_BITS-1:0]  lh_rdata, lhist_s1, lhist_next;
	logic [PATTERN_INDEX_BITS-1:0]  gh_pat, gidx_s1, aidx_s1;
	logic [GLOBAL_HISTORY_BITS-1:0] ghist_next;
	logic                           lh_we;

	// stage 2 combinational
	logic [CTR_BITS-1:0]           pa_rdata, pb_rdata, ch_rdata;
	logic [CTR_BITS-1:0]           ctr_a, ctr_b, chooser, sel_ctr, ctr_new, ch_new;
	logic [PATTERN_INDEX_BITS-1:0] sel_idx;
	logic                          use_local, pred_s2, ch_we;

	// table write ports, shared with the clearing pass
	logic                          pat_we, chs_we, loc_we;
	logic [PATTERN_INDEX_BITS-1:0] pat_waddr, chs_waddr;
	logic [CTR_BITS-1:0]           pat_wdata, chs_wdata;
	logic [LOCAL_INDEX_BITS-1:0]   loc_waddr;
	logic [PATTERN_INDEX_BITS-1:0] loc_wdata;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESET;
			pc_shift_q <= PC_SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q     <= cfg_wdata[MODE_BITS-1:0];
				CFG_PC_SHIFT: pc_shift_q <= cfg_wdata[SHIFT_BITS-1:0];
			endcase
		end
	end

	assign mode_tourn = (mode_q >= MODE_TOURNAMENT);
	assign upd_global = (mode_q == MODE_GLOBAL) || (mode_q == MODE_GSHARE) || mode_tourn;
	assign upd_local  = (mode_q >= MODE_LOCAL);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + CLEAR_BITS'(1);
			if (clr_cnt_q == '1) clr_q <= 1'b0;
		end
	end

	// pipeline flow: each stage loads when empty or when its occupant moves on
	assign load_s3  = !valid_s3 || result.ready;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign branch.ready = load_s1 && !clr_q;
	assign accept   = branch.valid && branch.ready;
	assign leave_s1 = valid_s1 && load_s2;
	assign leave_s2 = valid_s2 && load_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= accept;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 0: pc index extraction
	assign pc_shifted = branch.branch_pc >> pc_shift_q;
	assign pcv_in     = pc_shifted[PATTERN_INDEX_BITS-1:0];
	assign lix_in     = pc_shifted[LOCAL_INDEX_BITS-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			pcv_s1   <= pcv_in;
			lix_s1   <= lix_in;
			taken_s1 <= branch.taken;
		end
	end

	// local history table, read on acceptance
	tbp_ram #(
		.ADDR_BITS (LOCAL_INDEX_BITS),
		.DATA_BITS (PATTERN_INDEX_BITS)
	) u_local_hist (
		.clk   (clk),
		.we    (loc_we),
		.waddr (loc_waddr),
		.wdata (loc_wdata),
		.re    (accept),
		.raddr (lix_in),
		.rdata (lh_rdata)
	);

	// stage 1: histories and table indices
	assign lhist_s1   = (lbyp_v_q && (lbyp_addr_q == lix_s1)) ? lbyp_data_q : lh_rdata;
	assign lhist_next = PATTERN_INDEX_BITS'({lhist_s1, taken_s1});
	assign ghist_next = GLOBAL_HISTORY_BITS'({ghist_q, taken_s1});
	assign gh_pat     = PATTERN_INDEX_BITS'(ghist_q);
	assign gidx_s1    = (pcv_s1 >> GSHARE_PC_SHIFT) ^ gh_pat;
	assign lh_we      = leave_s1 && upd_local;

	// primary index; the tournament reads gshare here and local on the other bank
	always_comb begin
		unique case (mode_q)
			MODE_ONE_LEVEL: aidx_s1 = pcv_s1;
			MODE_GLOBAL:    aidx_s1 = gh_pat;
			MODE_GSHARE:    aidx_s1 = gidx_s1;
			MODE_LOCAL:     aidx_s1 = lhist_s1;
			default:        aidx_s1 = gidx_s1;
		endcase
	end

	// history updates as a branch leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q  <= '0;
			lbyp_v_q <= 1'b0;
		end else begin
			if (leave_s1 && upd_global) ghist_q <= ghist_next;
			if (lh_we) lbyp_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (lh_we) begin
			lbyp_addr_q <= lix_s1;
			lbyp_data_q <= lhist_next;
		end
		if (leave_s1) begin
			pcv_s2   <= pcv_s1;
			aidx_s2  <= aidx_s1;
			lidx_s2  <= lhist_s1;
			taken_s2 <= taken_s1;
		end
	end

	// pattern table, two banks holding the same contents
	tbp_ram #(
		.ADDR_BITS (PATTERN_INDEX_BITS),
		.DATA_BITS (CTR_BITS)
	) u_pattern_a (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.re    (leave_s1),
		.raddr (aidx_s1),
		.rdata (pa_rdata)
	);

	tbp_ram #(
		.ADDR_BITS (PATTERN_INDEX_BITS),
		.DATA_BITS (CTR_BITS)
	) u_pattern_b (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.re    (leave_s1),
		.raddr (lhist_s1),
		.rdata (pb_rdata)
	);

	// chooser table
	tbp_ram #(
		.ADDR_BITS (PATTERN_INDEX_BITS),
		.DATA_BITS (CTR_BITS)
	) u_chooser (
		.clk   (clk),
		.we    (chs_we),
		.waddr (chs_waddr),
		.wdata (chs_wdata),
		.re    (leave_s1),
		.raddr (pcv_s1),
		.rdata (ch_rdata)
	);

	// stage 2: forwarded counters, prediction and training
	assign ctr_a   = (pbyp_v_q && (pbyp_addr_q == aidx_s2)) ? pbyp_data_q : pa_rdata;
	assign ctr_b   = (pbyp_v_q && (pbyp_addr_q == lidx_s2)) ? pbyp_data_q : pb_rdata;
	assign chooser = (cbyp_v_q && (cbyp_addr_q == pcv_s2)) ? cbyp_data_q : ch_rdata;

	assign use_local = mode_tourn && chooser[1];
	assign sel_ctr   = use_local ? ctr_b : ctr_a;
	assign sel_idx   = use_local ? lidx_s2 : aidx_s2;
	assign pred_s2   = sel_ctr[1];
	assign ctr_new   = ctr_step(sel_ctr, taken_s2);

	// chooser moves toward whichever component was right, only when they disagree
	assign ch_we  = leave_s2 && mode_tourn && (ctr_a[1] != ctr_b[1]);
	assign ch_new = ctr_step(chooser, ctr_a[1] != taken_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbyp_v_q           <= 1'b0;
			cbyp_v_q           <= 1'b0;
			hits_taken_q       <= '0;
			misses_taken_q     <= '0;
			hits_not_taken_q   <= '0;
			misses_not_taken_q <= '0;
		end else begin
			if (leave_s2) begin
				pbyp_v_q <= 1'b1;
				// saturating outcome counts
				unique case ({taken_s2, pred_s2})
					2'b11: if (hits_taken_q != '1)
						hits_taken_q <= hits_taken_q + COUNT_BITS'(1);
					2'b10: if (misses_taken_q != '1)
						misses_taken_q <= misses_taken_q + COUNT_BITS'(1);
					2'b00: if (hits_not_taken_q != '1)
						hits_not_taken_q <= hits_not_taken_q + COUNT_BITS'(1);
					default: if (misses_not_taken_q != '1)
						misses_not_taken_q <= misses_not_taken_q + COUNT_BITS'(1);
				endcase
			end
			if (ch_we) cbyp_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s2) begin
			pbyp_addr_q <= sel_idx;
			pbyp_data_q <= ctr_new;
			pred_s3     <= pred_s2;
			correct_s3  <= (pred_s2 == taken_s2);
		end
		if (ch_we) begin
			cbyp_addr_q <= pcv_s2;
			cbyp_data_q <= ch_new;
		end
	end

	// table write ports: clearing pass has the ports until it ends
	always_comb begin
		if (clr_q) begin
			pat_we    = 1'b1;
			pat_waddr = clr_cnt_q[PATTERN_INDEX_BITS-1:0];
			pat_wdata = PATTERN_RESET;
			chs_we    = 1'b1;
			chs_waddr = clr_cnt_q[PATTERN_INDEX_BITS-1:0];
			chs_wdata = CHOOSER_RESET;
			loc_we    = 1'b1;
			loc_waddr = clr_cnt_q[LOCAL_INDEX_BITS-1:0];
			loc_wdata = '0;
		end else begin
			pat_we    = leave_s2;
			pat_waddr = sel_idx;
			pat_wdata = ctr_new;
			chs_we    = ch_we;
			chs_waddr = pcv_s2;
			chs_wdata = ch_new;
			loc_we    = lh_we;
			loc_waddr = lix_s1;
			loc_wdata = lhist_next;
		end
	end

	// result channel; counts only change when a new result is loaded
	assign result.valid            = valid_s3;
	assign result.predicted_taken  = pred_s3;
	assign result.correct          = correct_s3;
	assign result.hits_taken       = hits_taken_q;
	assign result.misses_taken     = misses_taken_q;
	assign result.hits_not_taken   = hits_not_taken_q;
	assign result.misses_not_taken = misses_not_taken_q;

`ifndef NO_ASSERTIONS
	// no branch is taken in while the tables are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !branch.ready)
		else $error("branch accepted during clearing pass");

	// clearing ends only after the last table entry was written
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> ($past(clr_cnt_q) == '1))
		else $error("clearing pass ended early");

	// a branch leaving training always shows up as a result next cycle
	a_train_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		leave_s2 |=> result.valid)
		else $error("trained branch lost before the result register");

	// an accepted branch occupies stage 1 next cycle
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted branch lost before stage 1");

	// outcome counts hits_taken and misses_not_taken never go down
	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |=> (hits_taken_q >= $past(hits_taken_q))
			&& (misses_not_taken_q >= $past(misses_not_taken_q)))
		else $error("outcome count decreased");
`endif

endmodule : tournament_branch_predictor

`default_nettype wire

// ----- rtl/tbp_ram.sv -----
// tbp_ram: generic one write port, one read port RAM with registered read data
// no dependencies; read of an address written in the same cycle returns the old data
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
	parameter int ADDR_BITS = 10,
	parameter int DATA_BITS = 2
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : tbp_ram

`default_nettype wire
